### sv/fasm_pkg.sv
// ============================================================================
// fasm_pkg: shared types and constants for the substring match finder
// Transfer structs, register indexes and pattern layout.
// ============================================================================
`default_nettype none

package fasm_pkg;

    localparam int PATTERN_BYTES = 16;
    localparam int LEN_W         = 5;
    localparam int FIELD_W       = 32;
    localparam int CFG_DATA_W    = 64;
    localparam int CFG_ADDR_W    = 5;

    // register indexes, byte address is 8 * index
    localparam logic [1:0] REG_PATTERN_LENGTH = 2'd0;
    localparam logic [1:0] REG_PATTERN_LOW    = 2'd1;
    localparam logic [1:0] REG_PATTERN_HIGH   = 2'd2;

    typedef logic [PATTERN_BYTES-1:0][7:0] pattern_t;

    typedef struct packed {
        logic [7:0] text_byte;
        logic       text_end;
    } text_item_t;

    typedef struct packed {
        logic               match_found;
        logic [FIELD_W-1:0] match_start;
        logic [FIELD_W-1:0] match_total;
        logic               text_done;
    } match_item_t;

    typedef struct packed {
        logic [LEN_W-1:0]      pattern_length;
        logic [CFG_DATA_W-1:0] pattern_low_bytes;
        logic [CFG_DATA_W-1:0] pattern_high_bytes;
    } cfg_t;

endpackage

`default_nettype wire

### sv/fasm_regs.sv
// ============================================================================
// fasm_regs: configuration register file
// APB-style slave holding pattern length and the sixteen pattern bytes.
// ============================================================================
`default_nettype none

module fasm_regs (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           psel,
    input  wire logic                           penable,
    input  wire logic                           pwrite,
    input  wire logic [fasm_pkg::CFG_ADDR_W-1:0] paddr,
    input  wire logic [fasm_pkg::CFG_DATA_W-1:0] pwdata,
    output logic      [fasm_pkg::CFG_DATA_W-1:0] prdata,
    output logic                                pready,
    output fasm_pkg::cfg_t                      cfg
);
    import fasm_pkg::*;

    logic [LEN_W-1:0]      len_reg;
    logic [CFG_DATA_W-1:0] low_reg;
    logic [CFG_DATA_W-1:0] high_reg;
    logic [1:0]            reg_index;
    logic                  wr_en;

    assign reg_index = paddr[4:3];
    assign wr_en     = psel && penable && pwrite;
    assign pready    = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            len_reg  <= '0;
            low_reg  <= '0;
            high_reg <= '0;
        end
        else if (wr_en)
        begin
            unique case (reg_index)
                REG_PATTERN_LENGTH: len_reg  <= pwdata[LEN_W-1:0];
                REG_PATTERN_LOW:    low_reg  <= pwdata;
                REG_PATTERN_HIGH:   high_reg <= pwdata;
                default:            ;
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_index)
            REG_PATTERN_LENGTH: prdata = {{(CFG_DATA_W-LEN_W){1'b0}}, len_reg};
            REG_PATTERN_LOW:    prdata = low_reg;
            REG_PATTERN_HIGH:   prdata = high_reg;
            default:            prdata = '0;
        endcase
    end

    assign cfg.pattern_length     = len_reg;
    assign cfg.pattern_low_bytes  = low_reg;
    assign cfg.pattern_high_bytes = high_reg;

endmodule

`default_nettype wire

### sv/fasm_cell.sv
// ============================================================================
// fasm_cell: one window slot of the match chain
// Holds one text byte, hands it on to the next slot and checks the incoming
// byte against the pattern byte that lines up with this slot.
// ============================================================================
`default_nettype none

module fasm_cell #(
    parameter int CELL_INDEX = 0
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        shift_en,
    input  wire logic                        clear,
    input  wire logic [7:0]                  byte_in,
    input  wire logic [fasm_pkg::LEN_W-1:0]  len_eff,
    input  wire fasm_pkg::pattern_t          pattern,
    output logic      [7:0]                  byte_out,
    output logic                             cmp_ok
);
    import fasm_pkg::*;

    localparam logic [LEN_W-1:0] SLOT = LEN_W'(CELL_INDEX);

    logic [7:0]       byte_reg;
    logic [LEN_W-1:0] pat_pos;
    logic             in_use;

    // slot k lines up with pattern byte len-1-k
    assign in_use  = len_eff > SLOT;
    assign pat_pos = len_eff - SLOT - LEN_W'(1);
    assign cmp_ok  = !in_use || (byte_in == pattern[pat_pos[3:0]]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            byte_reg <= '0;
        else if (shift_en)
            byte_reg <= clear ? 8'd0 : byte_in;
    end

    assign byte_out = byte_reg;

endmodule

`default_nettype wire

### sv/find_all_substring_matches.sv
// ============================================================================
// find_all_substring_matches: streaming all-occurrences substring search
// Reports the start index of every overlapping pattern match in a byte stream.
// ============================================================================
// The block takes one text byte per cycle and reports every occurrence of the
// configured pattern (up to PATTERN_MAX bytes) that ends at that byte,
// including overlapping ones, with the occurrence's zero-based start index and
// the running match count. The final byte of a text (text_end set) always
// yields a result with text_done set, after which the window, position and
// count return to zero; the pattern registers keep their values. A length of
// zero never matches; a length above PATTERN_MAX acts as PATTERN_MAX. Bytes
// that neither end a match nor close a text yield no result. Throughput is one
// byte per cycle: the whole window is compared in the same cycle the byte
// enters, one comparator per slot along the cell chain, and the result lands
// in a two-entry output buffer, so input stalls only when both entries are
// held by a stalled consumer. A result is registered there before it shows
// as valid. Program the registers over the APB port (64-bit data, register
// i at byte address 8*i) only while no text transfer is in flight.
// ============================================================================
`default_nettype none

module find_all_substring_matches #(
    parameter int PATTERN_MAX = 16,
    parameter int INDEX_WIDTH = 32
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    // text input channel
    input  wire logic                            text_valid,
    output logic                                 text_ready,
    input  wire fasm_pkg::text_item_t            text,
    // result channel
    output logic                                 match_valid,
    input  wire logic                            match_ready,
    output fasm_pkg::match_item_t                match,
    // configuration port
    input  wire logic                            psel,
    input  wire logic                            penable,
    input  wire logic                            pwrite,
    input  wire logic [fasm_pkg::CFG_ADDR_W-1:0] paddr,
    input  wire logic [fasm_pkg::CFG_DATA_W-1:0] pwdata,
    output logic      [fasm_pkg::CFG_DATA_W-1:0] prdata,
    output logic                                 pready
);
    import fasm_pkg::*;

    localparam logic [LEN_W-1:0]       LEN_MAX = LEN_W'(PATTERN_MAX);
    localparam logic [INDEX_WIDTH-1:0] IDX_MAX = '1;

    cfg_t cfg;

    fasm_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // Clamp the length and lay out the pattern bytes.
    logic [LEN_W-1:0] len_eff;
    pattern_t         pattern;

    assign len_eff = (cfg.pattern_length > LEN_MAX) ? LEN_MAX : cfg.pattern_length;
    assign pattern = {cfg.pattern_high_bytes, cfg.pattern_low_bytes};

    logic text_xfer;
    logic last;

    assign text_xfer = text_valid && text_ready;
    assign last      = text.text_end;

    // Cell chain: slot 0 takes the new byte, each slot passes its byte on.
    // Each cell compares the byte it is about to hold, so the compare sees
    // the window as it stands after this byte shifts in.
    logic [7:0]             chain [PATTERN_MAX+1];
    logic [PATTERN_MAX-1:0] cmp_ok;

    assign chain[0] = text.text_byte;

    for (genvar k = 0; k < PATTERN_MAX; k++)
    begin : g_cell
        fasm_cell #(
            .CELL_INDEX (k)
        ) u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .shift_en (text_xfer),
            .clear    (last),
            .byte_in  (chain[k]),
            .len_eff  (len_eff),
            .pattern  (pattern),
            .byte_out (chain[k+1]),
            .cmp_ok   (cmp_ok[k])
        );
    end

    // Position and match count, both saturating.
    logic [INDEX_WIDTH-1:0] pos_reg;
    logic [INDEX_WIDTH-1:0] pos_next;
    logic [INDEX_WIDTH-1:0] total_reg;
    logic [INDEX_WIDTH-1:0] total_next;
    logic [INDEX_WIDTH-1:0] total_inc;
    logic [INDEX_WIDTH-1:0] span;
    logic [INDEX_WIDTH-1:0] start;
    logic                   hit;
    logic                   emit;

    // span is len-1; a match needs at least len bytes of this text
    assign span  = INDEX_WIDTH'(len_eff) - INDEX_WIDTH'(1);
    assign hit   = (len_eff != '0) && (pos_reg >= span) && (&cmp_ok);
    assign start = hit ? (pos_reg - span) : '0;
    assign emit  = hit || last;

    assign total_inc = (hit && (total_reg != IDX_MAX)) ? total_reg + INDEX_WIDTH'(1)
                                                       : total_reg;

    always_comb
    begin
        pos_next   = pos_reg;
        total_next = total_reg;
        if (text_xfer)
        begin
            if (last)
            begin
                pos_next   = '0;
                total_next = '0;
            end
            else
            begin
                total_next = total_inc;
                if (pos_reg != IDX_MAX)
                    pos_next = pos_reg + INDEX_WIDTH'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg   <= '0;
            total_reg <= '0;
        end
        else
        begin
            pos_reg   <= pos_next;
            total_reg <= total_next;
        end
    end

    // Result for this byte.
    match_item_t result;

    assign result.match_found = hit;
    assign result.match_start = FIELD_W'(start);
    assign result.match_total = FIELD_W'(total_inc);
    assign result.text_done   = last;

    // Two-entry output buffer: a main slot driving the port and a skid slot
    // that catches one result while the consumer stalls.
    match_item_t out_reg;
    match_item_t skid_reg;
    logic        out_valid_reg;
    logic        skid_valid_reg;
    logic        push;
    logic        pop;

    assign text_ready = !skid_valid_reg;
    assign push       = text_xfer && emit;
    assign pop        = out_valid_reg && match_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (skid_valid_reg)
        begin
            // input is held off; drain skid into the main slot
            if (pop)
                skid_valid_reg <= 1'b0;
        end
        else if (push && out_valid_reg && !pop)
            skid_valid_reg <= 1'b1;
        else if (push)
            out_valid_reg <= 1'b1;
        else if (pop)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (skid_valid_reg)
        begin
            if (pop)
                out_reg <= skid_reg;
        end
        else if (push && out_valid_reg && !pop)
            skid_reg <= result;
        else if (push)
            out_reg <= result;
    end

    assign match_valid = out_valid_reg;
    assign match       = out_reg;

endmodule

`default_nettype wire
